### hw/rtl/counted_multiset_max_top_assert.svh
// assertion macros for the counted multiset block
`ifndef COUNTED_MULTISET_MAX_TOP_ASSERT_SVH
`define COUNTED_MULTISET_MAX_TOP_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define CMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define CMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cms_pkg.sv
// shared types and constants for the counted multiset block
package cms_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 16;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL = 2'd1;
    localparam logic [OP_W-1:0] OP_MAX = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // what the cell row does in the update cycle
    typedef enum logic [2:0] {
        MODE_NOP,
        MODE_INC,
        MODE_DEC,
        MODE_INS,
        MODE_DEL
    } cms_mode_t;

    typedef struct packed {
        logic      load;
        cms_mode_t mode;
    } cms_ctl_t;

endpackage

### hw/rtl/cms_cell.sv
// one entry of the sorted cell row: value, count and captured compare flags
module cms_cell #(
    parameter int VALUE_BITS = cms_pkg::VALUE_BITS,
    parameter int COUNT_BITS = cms_pkg::COUNT_BITS,
    parameter int USED_BITS  = 7,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cms_pkg::cms_ctl_t     ctl,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic [USED_BITS-1:0]  used,
    input  logic [VALUE_BITS-1:0] prev_value,
    input  logic [COUNT_BITS-1:0] prev_count,
    input  logic                  prev_gt,
    input  logic [VALUE_BITS-1:0] next_value,
    input  logic [COUNT_BITS-1:0] next_count,
    output logic [VALUE_BITS-1:0] value,
    output logic [COUNT_BITS-1:0] count,
    output logic                  gt,
    output logic                  match,
    output logic                  one
);

    localparam logic [USED_BITS-1:0] IDX = USED_BITS'(INDEX);

    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  match_reg, gt_reg, one_reg;
    logic                  occ;

    assign occ = IDX < used;

    // compare flags are taken when an item is accepted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
            gt_reg    <= 1'b0;
            one_reg   <= 1'b0;
        end else if (ctl.load) begin
            match_reg <= occ && (value_reg == in_value);
            // a free cell counts as smaller than anything
            gt_reg    <= !occ || ($signed(in_value) > $signed(value_reg));
            one_reg   <= count_reg == COUNT_BITS'(1);
        end
    end

    always_comb begin
        value_next = value_reg;
        count_next = count_reg;
        case (ctl.mode)
            cms_pkg::MODE_INC: begin
                if (match_reg && (count_reg != '1)) begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
            end
            cms_pkg::MODE_DEC: begin
                if (match_reg) begin
                    count_next = count_reg - COUNT_BITS'(1);
                end
            end
            cms_pkg::MODE_INS: begin
                // cells below the insert point move down by one
                if (gt_reg) begin
                    if (prev_gt) begin
                        value_next = prev_value;
                        count_next = prev_count;
                    end else begin
                        value_next = in_value;
                        count_next = COUNT_BITS'(1);
                    end
                end
            end
            cms_pkg::MODE_DEL: begin
                // the removed cell and all after it pull up by one
                if (gt_reg || match_reg) begin
                    value_next = next_value;
                    count_next = next_count;
                end
            end
            default: begin
                value_next = value_reg;
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        count_reg <= count_next;
    end

    assign value = value_reg;
    assign count = count_reg;
    assign gt    = gt_reg;
    assign match = match_reg;
    assign one   = one_reg;

endmodule

### hw/rtl/counted_multiset_max_top.sv
// counted multiset with maximum query, built as a sorted row of cells
//
//  channel | dir | fields (low bit up)              | accepted when
//  --------+-----+----------------------------------+----------------------
//  s_      | in  | op[1:0], value[VALUE_BITS-1:0]   | s_tvalid && s_tready
//  m_      | out | status[1:0], max_value[...]      | m_tvalid && m_tready
//
// the accept edge captures every cell's compare against the item; the
// ST_EXEC edge that takes the result updates the whole row at once
// cells stay sorted largest first, so max is read from the first cell
// a result waiting in the output register holds the update cycle only
// reset clears the entry count; cell contents past the count are never used
module counted_multiset_max_top #(
    parameter int CAPACITY   = cms_pkg::CAPACITY,
    parameter int VALUE_BITS = cms_pkg::VALUE_BITS,
    parameter int COUNT_BITS = cms_pkg::COUNT_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // op, value
    input  logic [((cms_pkg::OP_W+VALUE_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // status, max_value
    output logic [((cms_pkg::STATUS_W+VALUE_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int OP_W      = cms_pkg::OP_W;
    localparam int STATUS_W  = cms_pkg::STATUS_W;
    localparam int M_DATA_W  = ((STATUS_W + VALUE_BITS + 7) / 8) * 8;
    localparam int USED_BITS = $clog2(CAPACITY + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                  state_reg;
    logic [OP_W-1:0]         op_reg;
    logic [VALUE_BITS-1:0]   value_reg;
    logic [USED_BITS-1:0]    used_reg, used_next;
    logic                    m_tvalid_reg;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;
    logic [VALUE_BITS-1:0]   m_max_reg, m_max_next;

    logic [OP_W-1:0]         s_op;
    logic [VALUE_BITS-1:0]   s_value;
    logic                    s_fire, exec_fire;
    logic                    any_match, any_one, full;
    cms_pkg::cms_mode_t      mode;
    cms_pkg::cms_ctl_t       ctl;
    logic [VALUE_BITS-1:0]   row_value;

    logic [VALUE_BITS-1:0]   cell_value [CAPACITY];
    logic [COUNT_BITS-1:0]   cell_count [CAPACITY];
    logic [VALUE_BITS-1:0]   prv_value  [CAPACITY];
    logic [COUNT_BITS-1:0]   prv_count  [CAPACITY];
    logic [VALUE_BITS-1:0]   nxt_value  [CAPACITY];
    logic [COUNT_BITS-1:0]   nxt_count  [CAPACITY];
    logic [CAPACITY-1:0]     cell_gt, cell_match, cell_one, prv_gt;

    assign s_op    = s_tdata[OP_W-1:0];
    assign s_value = s_tdata[OP_W +: VALUE_BITS];

    assign s_tready  = state_reg == ST_IDLE;
    assign s_fire    = s_tvalid && s_tready;
    assign exec_fire = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

    assign any_match = |cell_match;
    assign any_one   = |(cell_match & cell_one);
    assign full      = used_reg == USED_BITS'(CAPACITY);

    always_comb begin
        mode          = cms_pkg::MODE_NOP;
        used_next     = used_reg;
        m_status_next = cms_pkg::STATUS_OK;
        m_max_next    = '0;
        case (op_reg)
            cms_pkg::OP_ADD: begin
                if (any_match) begin
                    mode = cms_pkg::MODE_INC;
                end else if (full) begin
                    m_status_next = cms_pkg::STATUS_FULL;
                end else begin
                    mode      = cms_pkg::MODE_INS;
                    used_next = used_reg + USED_BITS'(1);
                end
            end
            cms_pkg::OP_DEL: begin
                if (any_one) begin
                    mode      = cms_pkg::MODE_DEL;
                    used_next = used_reg - USED_BITS'(1);
                end else if (any_match) begin
                    mode = cms_pkg::MODE_DEC;
                end
            end
            cms_pkg::OP_MAX: begin
                if (used_reg == '0) begin
                    m_status_next = cms_pkg::STATUS_EMPTY;
                end else begin
                    m_max_next = cell_value[0];
                end
            end
            default: begin
                mode = cms_pkg::MODE_NOP;
            end
        endcase
    end

    assign ctl.load  = s_fire;
    assign ctl.mode  = exec_fire ? mode : cms_pkg::MODE_NOP;
    // compare against the incoming item, insert the held one
    assign row_value = (state_reg == ST_IDLE) ? s_value : value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_status_reg <= cms_pkg::STATUS_OK;
            m_max_reg    <= '0;
        end else begin
            if (exec_fire) begin
                m_tvalid_reg <= 1'b1;
                m_status_reg <= m_status_next;
                m_max_reg    <= m_max_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (exec_fire) begin
                        state_reg <= ST_IDLE;
                        used_reg  <= used_next;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg    <= s_op;
            value_reg <= s_value;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({m_max_reg, m_status_reg});

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign prv_value[i] = '0;
            assign prv_count[i] = '0;
            assign prv_gt[i]    = 1'b0;
        end else begin : g_body
            assign prv_value[i] = cell_value[i-1];
            assign prv_count[i] = cell_count[i-1];
            assign prv_gt[i]    = cell_gt[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign nxt_value[i] = cell_value[i];
            assign nxt_count[i] = cell_count[i];
        end else begin : g_link
            assign nxt_value[i] = cell_value[i+1];
            assign nxt_count[i] = cell_count[i+1];
        end

        cms_cell #(
            .VALUE_BITS (VALUE_BITS),
            .COUNT_BITS (COUNT_BITS),
            .USED_BITS  (USED_BITS),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .in_value   (row_value),
            .used       (used_reg),
            .prev_value (prv_value[i]),
            .prev_count (prv_count[i]),
            .prev_gt    (prv_gt[i]),
            .next_value (nxt_value[i]),
            .next_count (nxt_count[i]),
            .value      (cell_value[i]),
            .count      (cell_count[i]),
            .gt         (cell_gt[i]),
            .match      (cell_match[i]),
            .one        (cell_one[i])
        );
    end

endmodule

### hw/rtl/cms_checker.sv
// port-level checks for the counted multiset block, bound to the top level
`include "counted_multiset_max_top_assert.svh"

module cms_checker #(
    parameter int VALUE_BITS = cms_pkg::VALUE_BITS
) (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((cms_pkg::STATUS_W+VALUE_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int MAX_LSB = cms_pkg::STATUS_W;

    logic [cms_pkg::STATUS_W-1:0] status;
    logic [VALUE_BITS-1:0]        max_value;

    assign status    = m_tdata[cms_pkg::STATUS_W-1:0];
    assign max_value = m_tdata[MAX_LSB +: VALUE_BITS];

    `CMS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")

    `CMS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "item accepted while previous one in update")

    `CMS_ASSERT_NOW(a_status_code, m_tvalid, (status == cms_pkg::STATUS_OK) || (status == cms_pkg::STATUS_EMPTY) || (status == cms_pkg::STATUS_FULL), "undefined status code")

    `CMS_ASSERT_NOW(a_max_zero, m_tvalid && (status != cms_pkg::STATUS_OK), max_value == '0, "max value nonzero on error status")

endmodule

bind counted_multiset_max_top cms_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_cms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/tb_top.sv
// self-checking testbench for counted_multiset_max_top: directed table, random mix
module tb_top;

    localparam int CAPACITY   = cms_pkg::CAPACITY;
    localparam int VALUE_BITS = cms_pkg::VALUE_BITS;
    localparam int COUNT_BITS = cms_pkg::COUNT_BITS;
    localparam int OP_W       = cms_pkg::OP_W;
    localparam int STATUS_W   = cms_pkg::STATUS_W;
    localparam logic [OP_W-1:0] OP_ADD = cms_pkg::OP_ADD;
    localparam logic [OP_W-1:0] OP_DEL = cms_pkg::OP_DEL;
    localparam logic [OP_W-1:0] OP_MAX = cms_pkg::OP_MAX;
    localparam logic [STATUS_W-1:0] STATUS_OK    = cms_pkg::STATUS_OK;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = cms_pkg::STATUS_EMPTY;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = cms_pkg::STATUS_FULL;

    localparam int S_W = ((OP_W + VALUE_BITS + 7) / 8) * 8;
    localparam int M_W = ((STATUS_W + VALUE_BITS + 7) / 8) * 8;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam logic [VALUE_BITS-1:0] MIN_VAL = 32'h8000_0000;
    localparam logic [VALUE_BITS-1:0] MAX_VAL = 32'h7FFF_FFFF;
    localparam logic [VALUE_BITS-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int POOL_SIZE = 48;
    localparam int DIR_ROWS = 23;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [VALUE_BITS-1:0] max_value;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [VALUE_BITS-1:0] value;
        logic                  typed;
        logic [STATUS_W-1:0]   status;
        logic [VALUE_BITS-1:0] max_value;
    } dir_row_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    // shadow copy of the multiset
    logic signed [VALUE_BITS-1:0] set_vals [CAPACITY];
    logic [COUNT_BITS-1:0]        set_cnts [CAPACITY];
    int                           set_used = 0;

    result_t                      pending_results [$];
    logic [VALUE_BITS-1:0]        value_pool [POOL_SIZE];
    int                           mismatches = 0;
    int                           cycle_count = 0;
    int                           src_idle_pct = 0;
    int                           snk_idle_pct = 0;
    logic                         hold_req = 1'b0;
    logic                         hold_on = 1'b0;

    // expected is typed in only where it reads off at a glance
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{OP_MAX,  32'd0,         1'b1, STATUS_EMPTY, 32'd0},   // max on empty set
        '{OP_DEL,  32'd5,         1'b1, STATUS_OK,    32'd0},   // delete of absent value
        '{OP_NONE, ALL_ONES,      1'b1, STATUS_OK,    32'd0},   // unused opcode
        '{OP_ADD,  MIN_VAL,       1'b1, STATUS_OK,    32'd0},
        '{OP_MAX,  32'd0,         1'b1, STATUS_OK,    MIN_VAL},
        '{OP_ADD,  MAX_VAL,       1'b1, STATUS_OK,    32'd0},
        '{OP_MAX,  ALL_ONES,      1'b1, STATUS_OK,    MAX_VAL},
        '{OP_ADD,  MAX_VAL,       1'b0, STATUS_OK,    32'd0},
        '{OP_DEL,  MAX_VAL,       1'b0, STATUS_OK,    32'd0},
        '{OP_MAX,  32'd0,         1'b1, STATUS_OK,    MAX_VAL},
        '{OP_DEL,  MAX_VAL,       1'b0, STATUS_OK,    32'd0},
        '{OP_MAX,  32'd0,         1'b1, STATUS_OK,    MIN_VAL},
        '{OP_ADD,  ALL_ONES,      1'b0, STATUS_OK,    32'd0},
        '{OP_ADD,  32'd0,         1'b0, STATUS_OK,    32'd0},
        '{OP_MAX,  32'd0,         1'b0, STATUS_OK,    32'd0},
        '{OP_DEL,  32'd0,         1'b0, STATUS_OK,    32'd0},
        '{OP_MAX,  32'd0,         1'b0, STATUS_OK,    32'd0},
        '{OP_DEL,  MIN_VAL,       1'b0, STATUS_OK,    32'd0},
        '{OP_DEL,  ALL_ONES,      1'b0, STATUS_OK,    32'd0},
        '{OP_MAX,  32'd0,         1'b1, STATUS_EMPTY, 32'd0},
        '{OP_ADD,  32'd1,         1'b0, STATUS_OK,    32'd0},
        '{OP_DEL,  32'h0001_2345, 1'b1, STATUS_OK,    32'd0},
        '{OP_MAX,  32'hAAAA_5555, 1'b0, STATUS_OK,    32'd0}
    };

    counted_multiset_max_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // applies one item to the shadow multiset and returns its result
    function automatic result_t multiset_step(input logic [OP_W-1:0] op,
                                              input logic [VALUE_BITS-1:0] val);
        result_t res;
        int slot;
        logic signed [VALUE_BITS-1:0] best;
        res = '0;
        slot = -1;
        for (int i = 0; i < set_used; i++) begin
            if (slot < 0 && set_vals[i] == val) slot = i;
        end
        case (op)
            OP_ADD: begin
                if (slot >= 0) begin
                    if (set_cnts[slot] != '1) set_cnts[slot] = set_cnts[slot] + 1'b1;
                end else if (set_used >= CAPACITY) begin
                    res.status = STATUS_FULL;
                end else begin
                    set_vals[set_used] = val;
                    set_cnts[set_used] = COUNT_BITS'(1);
                    set_used++;
                end
            end
            OP_DEL: begin
                if (slot >= 0) begin
                    if (set_cnts[slot] > 1) begin
                        set_cnts[slot] = set_cnts[slot] - 1'b1;
                    end else begin
                        // last valid entry fills the hole
                        set_vals[slot] = set_vals[set_used-1];
                        set_cnts[slot] = set_cnts[set_used-1];
                        set_used--;
                    end
                end
            end
            OP_MAX: begin
                if (set_used == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    best = set_vals[0];
                    for (int i = 1; i < set_used; i++) begin
                        if (set_vals[i] > best) best = set_vals[i];
                    end
                    res.max_value = best;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // s_tvalid stays high between back-to-back items
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_BITS-1:0] val,
                             input logic typed, input result_t typed_res);
        result_t predicted;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_W-OP_W-VALUE_BITS){1'b0}}, val, op};
        do @(posedge aclk); while (!s_tready);
        predicted = multiset_step(op, val);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic send_random();
        int r;
        logic [OP_W-1:0] op;
        logic [VALUE_BITS-1:0] val;
        r = $urandom_range(0, 99);
        val = $urandom;
        if (r < 48) begin
            op = OP_ADD;
            if ($urandom_range(0, 99) < 60) val = value_pool[$urandom_range(0, POOL_SIZE-1)];
        end else if (r < 80) begin
            op = OP_DEL;
            r = $urandom_range(0, 99);
            if (r < 70 && set_used > 0) val = set_vals[$urandom_range(0, set_used-1)];
            else if (r < 85) val = value_pool[$urandom_range(0, POOL_SIZE-1)];
        end else if (r < 95) begin
            op = OP_MAX;
        end else begin
            op = OP_NONE;
        end
        send_item(op, val, 1'b0, '0);
    endtask

    // receiver side
    always @(posedge aclk) begin
        if (!aresetn || hold_on) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // long receiver hold-off while the sender keeps offering items
    initial begin
        wait (hold_req);
        @(posedge aclk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_on <= 1'b0;
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status    = m_tdata[STATUS_W-1:0];
            got.max_value = m_tdata[STATUS_W +: VALUE_BITS];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: status %0d max_value %h",
                             got.status, got.max_value);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.max_value !== want.max_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status exp %0d got %0d, max_value exp %h got %h",
                                 want.status, got.status, want.max_value, got.max_value);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        value_pool[0] = MIN_VAL;
        value_pool[1] = MAX_VAL;
        value_pool[2] = ALL_ONES;
        value_pool[3] = '0;
        value_pool[4] = 32'd1;
        for (int i = 5; i < POOL_SIZE; i++) value_pool[i] = $urandom;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        snk_idle_pct = 58;
        src_idle_pct = 7;
        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                      {directed_rows[i].status, directed_rows[i].max_value});

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 58 : 0;
            snk_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 7 : 0;
            if (phase == 2) hold_req = 1'b1;
            for (int n = 0; n < 225; n++) send_random();
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/cms_pkg.sv
hw/rtl/cms_cell.sv
hw/rtl/counted_multiset_max_top.sv
hw/rtl/cms_checker.sv
tb/tb_top.sv
